// ===== rtl/core/mbps_pkg.sv =====
// Shared types and constants for the masked byte pattern scanner.
// Used by every module in rtl/core; depends on nothing.
package mbps_pkg;

  localparam int PATTERN_MAX_DEF = 16;
  localparam int OFFSET_BITS_DEF = 32;
  localparam int PATTERN_SLOTS   = 16;
  localparam int MATCH_OFS_W     = 32;
  localparam int QUEUE_DEPTH     = 4;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 64;
  localparam int LEN_CFG_W       = 5;

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CARE_MASK    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LEN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REPORT_ALL   = 3'd4;

  localparam logic KIND_MATCH   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_buffer;
  } in_item_t;

  typedef struct packed {
    logic                   result_kind;
    logic [MATCH_OFS_W-1:0] match_offset;
    logic                   any_found;
    logic                   last_of_run;
  } out_item_t;

  // One queued job: what a single accepted byte has to emit.
  typedef struct packed {
    logic                   has_match;
    logic                   is_last;
    logic                   any_found;
    logic [MATCH_OFS_W-1:0] match_offset;
  } job_t;

endpackage

// ===== rtl/core/mbps_front.sv =====
// Front end of the scanner: configuration registers, byte window, offset
// counter and the parallel masked compare. Depends on mbps_pkg.
module mbps_front #(
  parameter int PATTERN_MAX = mbps_pkg::PATTERN_MAX_DEF,
  parameter int OFFSET_BITS = mbps_pkg::OFFSET_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  input  logic [mbps_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mbps_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  mbps_pkg::in_item_t               in_data,
  input  logic                             q_full,
  output logic                             q_push,
  output mbps_pkg::job_t                   q_push_data
);

  localparam int IDXW  = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int LENW  = $clog2(PATTERN_MAX + 1);
  localparam int CMPW  = (LENW > mbps_pkg::LEN_CFG_W) ? LENW : mbps_pkg::LEN_CFG_W;
  localparam int WIDEW = (OFFSET_BITS > mbps_pkg::MATCH_OFS_W) ?
                         OFFSET_BITS : mbps_pkg::MATCH_OFS_W;

  logic [63:0]                       pat_lo_r;
  logic [63:0]                       pat_hi_r;
  logic [mbps_pkg::PATTERN_SLOTS-1:0] care_r;
  logic [mbps_pkg::LEN_CFG_W-1:0]    len_r;
  logic                              report_all_r;

  logic [7:0]             window_r   [PATTERN_MAX];
  logic [7:0]             window_nxt [PATTERN_MAX];
  logic [OFFSET_BITS-1:0] seen_r;
  logic [OFFSET_BITS-1:0] seen_nxt;
  logic                   mseen_r;
  logic                   mseen_nxt;

  logic [127:0]           pat_all;
  logic [CMPW-1:0]        len_w;
  logic [LENW-1:0]        len_eff;
  logic [PATTERN_MAX-1:0] pos_eq;
  logic                   hit;
  logic                   match_fire;
  logic                   accept;
  logic [OFFSET_BITS-1:0] ofs_full;
  logic [WIDEW-1:0]       ofs_wide;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_lo_r     <= '0;
      pat_hi_r     <= '0;
      care_r       <= '0;
      len_r        <= mbps_pkg::LEN_CFG_W'(1);
      report_all_r <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        mbps_pkg::REG_PATTERN_LOW:  pat_lo_r     <= cfg_data;
        mbps_pkg::REG_PATTERN_HIGH: pat_hi_r     <= cfg_data;
        mbps_pkg::REG_CARE_MASK:    care_r       <= cfg_data[mbps_pkg::PATTERN_SLOTS-1:0];
        mbps_pkg::REG_PATTERN_LEN:  len_r        <= cfg_data[mbps_pkg::LEN_CFG_W-1:0];
        mbps_pkg::REG_REPORT_ALL:   report_all_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign pat_all = {pat_hi_r, pat_lo_r};
  assign len_w   = (CMPW'(len_r) > CMPW'(PATTERN_MAX)) ? CMPW'(PATTERN_MAX) : CMPW'(len_r);
  assign len_eff = LENW'(len_w);
  assign accept  = in_valid && in_ready;
  assign in_ready = !q_full;

  // The newest byte sits at index 0; pattern byte j lines up with
  // window entry len-1-j so that the last pattern byte meets the newest byte.
  always_comb begin
    window_nxt[0] = in_data.data_byte;
    for (int i = 1; i < PATTERN_MAX; i++) begin
      window_nxt[i] = window_r[i-1];
    end
    for (int j = 0; j < PATTERN_MAX; j++) begin
      pos_eq[j] = 1'b1;
      if ((j < mbps_pkg::PATTERN_SLOTS) && (j < int'(len_eff)) && care_r[j & 15]) begin
        pos_eq[j] = (window_nxt[IDXW'(int'(len_eff) - 1 - j)] == pat_all[(j & 15)*8 +: 8]);
      end
    end
  end

  assign seen_nxt = (seen_r == {OFFSET_BITS{1'b1}}) ? seen_r : seen_r + OFFSET_BITS'(1);
  assign hit = (len_eff != '0) && (seen_nxt >= OFFSET_BITS'(len_eff)) && (&pos_eq);
  assign match_fire = hit && (report_all_r || !mseen_r);
  assign mseen_nxt = mseen_r || match_fire;
  assign ofs_full = seen_nxt - OFFSET_BITS'(len_eff);
  assign ofs_wide = WIDEW'(ofs_full);

  assign q_push = accept && (match_fire || in_data.end_of_buffer);
  always_comb begin
    q_push_data.has_match    = match_fire;
    q_push_data.is_last      = in_data.end_of_buffer;
    q_push_data.any_found    = mseen_nxt;
    q_push_data.match_offset = ofs_wide[mbps_pkg::MATCH_OFS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PATTERN_MAX; i++) window_r[i] <= '0;
      seen_r  <= '0;
      mseen_r <= 1'b0;
    end else if (accept) begin
      if (in_data.end_of_buffer) begin
        for (int i = 0; i < PATTERN_MAX; i++) window_r[i] <= '0;
        seen_r  <= '0;
        mseen_r <= 1'b0;
      end else begin
        for (int i = 0; i < PATTERN_MAX; i++) window_r[i] <= window_nxt[i];
        seen_r  <= seen_nxt;
        mseen_r <= mseen_nxt;
      end
    end
  end

endmodule

// ===== rtl/core/mbps_queue.sv =====
// Short job queue between the front end and the result stage.
// Depends on mbps_pkg for the job type and depth.
module mbps_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  mbps_pkg::job_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output mbps_pkg::job_t head_data
);

  localparam int AW = $clog2(mbps_pkg::QUEUE_DEPTH);

  mbps_pkg::job_t entry_r [mbps_pkg::QUEUE_DEPTH];
  logic [AW-1:0]  wr_ptr_r;
  logic [AW-1:0]  rd_ptr_r;
  logic [AW:0]    count_r;
  logic [AW:0]    count_nxt;
  logic           do_push;
  logic           do_pop;

  assign full       = (count_r == (AW+1)'(mbps_pkg::QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_data  = entry_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) count_nxt = count_r + (AW+1)'(1);
    if (!do_push && do_pop) count_nxt = count_r - (AW+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (do_push) entry_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + AW'(1);
      if (do_pop)  rd_ptr_r <= rd_ptr_r + AW'(1);
      count_r <= count_nxt;
    end
  end

endmodule

// ===== rtl/core/mbps_back.sv =====
// Result stage: turns queued jobs into match and summary items and holds
// them in the output register. Depends on mbps_pkg.
module mbps_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  mbps_pkg::job_t      q_head,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output mbps_pkg::out_item_t out_data
);

  logic                out_valid_r;
  logic                out_valid_nxt;
  mbps_pkg::out_item_t out_r;
  mbps_pkg::out_item_t out_nxt;
  logic                pend_r;
  logic                pend_nxt;
  logic                pend_any_r;
  logic                pend_any_nxt;
  logic                load;

  assign load  = !out_valid_r || out_ready;
  assign q_pop = load && !pend_r && q_valid;

  // A job with both a match and an end mark emits the match first and
  // parks the summary in pend_r until the output register can take it.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    pend_nxt      = pend_r;
    pend_any_nxt  = pend_any_r;
    if (load) begin
      out_valid_nxt = 1'b0;
      if (pend_r) begin
        out_valid_nxt        = 1'b1;
        out_nxt.result_kind  = mbps_pkg::KIND_SUMMARY;
        out_nxt.match_offset = '0;
        out_nxt.any_found    = pend_any_r;
        out_nxt.last_of_run  = 1'b1;
        pend_nxt             = 1'b0;
      end else if (q_valid) begin
        out_valid_nxt = 1'b1;
        if (q_head.has_match) begin
          out_nxt.result_kind  = mbps_pkg::KIND_MATCH;
          out_nxt.match_offset = q_head.match_offset;
          out_nxt.any_found    = 1'b0;
          out_nxt.last_of_run  = !q_head.is_last;
          pend_nxt             = q_head.is_last;
          pend_any_nxt         = q_head.any_found;
        end else begin
          out_nxt.result_kind  = mbps_pkg::KIND_SUMMARY;
          out_nxt.match_offset = '0;
          out_nxt.any_found    = q_head.any_found;
          out_nxt.last_of_run  = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    out_r      <= out_nxt;
    pend_any_r <= pend_any_nxt;
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== rtl/core/masked_byte_pattern_scanner.sv =====
// Top level of the masked byte pattern scanner.
// Instantiates mbps_front, mbps_queue and mbps_back; depends on mbps_pkg.
//
// The scanner takes one byte per clock cycle, sustained, whenever the result
// side keeps up: the masked compare of all pattern positions against the
// window is done in the cycle the byte is accepted, and the result stage
// drains one job per cycle into the output register when it is not stalled
// and no summary is parked. Each byte's job goes through the job queue into
// the output register, which presents its first result. An end-of-buffer
// byte that also completes a match yields two items, match then summary,
// which the four-entry job queue absorbs. No clearing pass follows reset.
// Configuration is taken every cycle and must only be written while idle.
module masked_byte_pattern_scanner #(
  parameter int PATTERN_MAX = mbps_pkg::PATTERN_MAX_DEF,
  parameter int OFFSET_BITS = mbps_pkg::OFFSET_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mbps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mbps_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  mbps_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output mbps_pkg::out_item_t             out_data
);

  logic           q_full;
  logic           q_push;
  mbps_pkg::job_t q_push_data;
  logic           q_pop;
  logic           q_valid;
  mbps_pkg::job_t q_head;

  assign cfg_ready = 1'b1;

  mbps_front #(
    .PATTERN_MAX(PATTERN_MAX),
    .OFFSET_BITS(OFFSET_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_push_data(q_push_data)
  );

  mbps_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .head_valid(q_valid),
    .head_data (q_head)
  );

  mbps_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

// ===== rtl/core/mbps_checker.sv =====
// Port-level checks for the masked byte pattern scanner, bound to the top.
// Depends on mbps_pkg and masked_byte_pattern_scanner.
module mbps_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input mbps_pkg::out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_summary_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.result_kind == mbps_pkg::KIND_SUMMARY) |->
      out_data.last_of_run && (out_data.match_offset == '0))
    else $error("summary item not final or has an offset");

  a_match_no_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.result_kind == mbps_pkg::KIND_MATCH) |->
      !out_data.any_found)
    else $error("match item carries found flag");

  a_match_then_summary: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && (out_data.result_kind == mbps_pkg::KIND_MATCH) &&
      !out_data.last_of_run |=>
      out_valid && (out_data.result_kind == mbps_pkg::KIND_SUMMARY) && out_data.any_found)
    else $error("match at buffer end not followed by its summary");

endmodule

bind masked_byte_pattern_scanner mbps_checker u_mbps_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for masked_byte_pattern_scanner: streams byte items and register
// writes, predicts each match and end-of-buffer result, and checks them in arrival order.
// Depends on mbps_pkg and the scanner RTL under rtl/core.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WINDOW       = 16;
  localparam int STALL_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 6;
  localparam int MAX_REPORTS  = 10;
  localparam int PHASES       = 12;
  localparam int PHASE_ITEMS  = 150;

  logic                            clk       = 1'b0;
  logic                            rst_n     = 1'b0;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [mbps_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [mbps_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
  logic                            in_valid  = 1'b0;
  logic                            in_ready;
  mbps_pkg::in_item_t              in_data   = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  mbps_pkg::out_item_t             out_data;

  masked_byte_pattern_scanner uut (.*);

  // Shadow copy of the registers and of the scan state.
  logic [63:0] sh_pat_lo;
  logic [63:0] sh_pat_hi;
  logic [15:0] sh_care;
  logic [4:0]  sh_len;
  logic        sh_report_all;
  logic [7:0]  sh_window [WINDOW];
  logic [31:0] sh_count;
  logic        sh_found;

  mbps_pkg::out_item_t expected_results[$];
  int mismatches    = 0;
  int in_gap_max    = 9;
  int out_stall_max = 9;
  int quiet_cycles  = 0;

  always #5 clk = ~clk;

  function automatic void clear_scan();
    foreach (sh_window[i]) sh_window[i] = '0;
    sh_count = '0;
    sh_found = 1'b0;
  endfunction

  function automatic logic [7:0] pattern_at(int j);
    return (j < 8) ? sh_pat_lo[8*j +: 8] : sh_pat_hi[8*(j-8) +: 8];
  endfunction

  function automatic int active_length();
    return (sh_len > WINDOW) ? WINDOW : int'(sh_len);
  endfunction

  function automatic void apply_reg(logic [mbps_pkg::CFG_IDX_W-1:0] idx, logic [63:0] value);
    case (idx)
      mbps_pkg::REG_PATTERN_LOW:  sh_pat_lo = value;
      mbps_pkg::REG_PATTERN_HIGH: sh_pat_hi = value;
      mbps_pkg::REG_CARE_MASK:    sh_care = value[15:0];
      mbps_pkg::REG_PATTERN_LEN:  sh_len = value[4:0];
      mbps_pkg::REG_REPORT_ALL:   sh_report_all = value[0];
      default: ;
    endcase
  endfunction

  // Shifts one byte into the window and queues the results it causes.
  function automatic void scan_byte(mbps_pkg::in_item_t item);
    int                  len;
    logic                hit;
    mbps_pkg::out_item_t r;
    len = active_length();
    for (int i = WINDOW - 1; i > 0; i--) sh_window[i] = sh_window[i-1];
    sh_window[0] = item.data_byte;
    if (sh_count != '1) sh_count++;
    hit = (len > 0) && (sh_count >= len);
    // Pattern byte j lines up with the byte that arrived len-1-j items ago.
    for (int j = 0; j < len; j++)
      if (sh_care[j] && sh_window[len-1-j] != pattern_at(j)) hit = 1'b0;
    if (hit && (sh_report_all || !sh_found)) begin
      r.result_kind  = mbps_pkg::KIND_MATCH;
      r.match_offset = sh_count - len;
      r.any_found    = 1'b0;
      r.last_of_run  = !item.end_of_buffer;
      expected_results.insert(expected_results.size(), r);
      sh_found = 1'b1;
    end
    if (item.end_of_buffer) begin
      r.result_kind  = mbps_pkg::KIND_SUMMARY;
      r.match_offset = '0;
      r.any_found    = sh_found;
      r.last_of_run  = 1'b1;
      expected_results.insert(expected_results.size(), r);
      clear_scan();
    end
  endfunction

  function automatic void check_result(mbps_pkg::out_item_t got);
    mbps_pkg::out_item_t want;
    if (expected_results.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("ERROR: unexpected result kind=%0d offset=%0d any=%0d last=%0d",
                 got.result_kind, got.match_offset, got.any_found, got.last_of_run);
      return;
    end
    want = expected_results.pop_front();
    if (got.result_kind !== want.result_kind || got.match_offset !== want.match_offset ||
        got.any_found !== want.any_found || got.last_of_run !== want.last_of_run) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display({"ERROR: expected kind=%0d offset=%0d any=%0d last=%0d, ",
                  "got kind=%0d offset=%0d any=%0d last=%0d"},
                 want.result_kind, want.match_offset, want.any_found, want.last_of_run,
                 got.result_kind, got.match_offset, got.any_found, got.last_of_run);
    end
  endfunction

  // Keeps cfg_valid high between writes unless release_after is set.
  task automatic write_reg(input logic [mbps_pkg::CFG_IDX_W-1:0] idx,
                           input logic [63:0] value, input bit release_after);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, value);
    if (release_after) cfg_valid <= 1'b0;
  endtask

  task automatic program_scan(input logic [63:0] lo, input logic [63:0] hi,
                              input logic [63:0] care, input logic [63:0] len,
                              input logic [63:0] report_all);
    write_reg(mbps_pkg::REG_PATTERN_LOW, lo, 1'b0);
    write_reg(mbps_pkg::REG_PATTERN_HIGH, hi, 1'b0);
    write_reg(mbps_pkg::REG_CARE_MASK, care, 1'b0);
    write_reg(mbps_pkg::REG_PATTERN_LEN, len, 1'b0);
    write_reg(mbps_pkg::REG_REPORT_ALL, report_all, 1'b1);
  endtask

  task automatic send_byte(input logic [7:0] value, input logic eob);
    int                 gap;
    mbps_pkg::in_item_t item;
    gap = (in_gap_max == 0) ? 0 : $urandom_range(0, in_gap_max);
    item.data_byte     = value;
    item.end_of_buffer = eob;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    scan_byte(item);
  endtask

  // Holds the sender off until every queued result is out, then lets the pipeline empty.
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic test_reset_defaults();
    // Length one with every position a wildcard: each byte is a match.
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
  endtask

  task automatic test_zero_length();
    drain();
    program_scan('1, '1, '1, 64'd0, 64'd1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
  endtask

  task automatic test_long_pattern();
    drain();
    // A length above the window is clamped; the match ends on the final byte,
    // so the match item must come before the summary.
    program_scan('1, '0, 64'hFFFF, 64'd31, 64'd1);
    for (int k = 0; k < WINDOW; k++) send_byte((k < 8) ? 8'hFF : 8'h00, k == WINDOW - 1);
  endtask

  task automatic test_first_only();
    drain();
    program_scan(64'h5A, '1, 64'h0001, 64'd1, 64'd0);
    for (int k = 0; k < 3; k++) send_byte(8'h5A, k == 2);
  endtask

  task automatic test_short_buffer();
    drain();
    write_reg(mbps_pkg::REG_PATTERN_LEN, 64'd2, 1'b0);
    write_reg(mbps_pkg::REG_CARE_MASK, 64'd0, 1'b0);
    write_reg(mbps_pkg::REG_REPORT_ALL, 64'd1, 1'b1);
    send_byte(8'hC3, 1'b1);
  endtask

  task automatic test_unknown_index();
    drain();
    for (int idx = mbps_pkg::REG_REPORT_ALL + 1; idx < (1 << mbps_pkg::CFG_IDX_W); idx++)
      write_reg(mbps_pkg::CFG_IDX_W'(idx), {$urandom, $urandom},
                idx == (1 << mbps_pkg::CFG_IDX_W) - 1);
    send_byte(8'h3C, 1'b0);
    send_byte(8'h96, 1'b1);
  endtask

  // One buffer built from planted pattern copies, pattern bytes and noise.
  task automatic scan_random_buffer(inout int sent, input bit pause_inside);
    logic [7:0] bytes[$];
    int         blen;
    int         len;
    int         pause_at;
    len  = active_length();
    blen = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 48);
    while (bytes.size() < blen) begin
      case ($urandom_range(0, 3))
        0: for (int j = 0; j < len; j++)
             bytes.insert(bytes.size(),
                          sh_care[j] ? pattern_at(j) : 8'($urandom_range(0, 255)));
        1: bytes.insert(bytes.size(), pattern_at($urandom_range(0, (len > 0) ? len - 1 : 0)));
        default: bytes.insert(bytes.size(), 8'($urandom_range(0, 255)));
      endcase
    end
    pause_at = pause_inside ? blen / 2 : -1;
    for (int k = 0; k < blen; k++) begin
      if (k == pause_at) drain();
      send_byte(bytes[k], k == blen - 1);
    end
    sent += blen;
  endtask

  task automatic test_random_scan();
    int          sent;
    logic [63:0] care;
    logic [4:0]  len;
    for (int phase = 0; phase < PHASES; phase++) begin
      drain();
      case ($urandom_range(0, 3))
        0: care = '0;
        1: care = '1;
        default: care = {$urandom, $urandom};
      endcase
      case ($urandom_range(0, 9))
        0: len = 5'd0;
        1: len = 5'($urandom_range(17, 31));
        2: len = 5'd16;
        default: len = 5'($urandom_range(1, 8));
      endcase
      program_scan({$urandom, $urandom}, {$urandom, $urandom}, care,
                   {$urandom, 27'($urandom), len}, {$urandom, $urandom});
      in_gap_max    = ($urandom_range(0, 2) == 0) ? 0 : 9;
      out_stall_max = ($urandom_range(0, 2) == 0) ? 0 : 9;
      sent = 0;
      while (sent < PHASE_ITEMS) scan_random_buffer(sent, phase == 3 && sent == 0);
    end
  endtask

  initial begin : result_checker
    int stall;
    wait (rst_n);
    @(posedge clk);
    forever begin
      stall = (out_stall_max == 0) ? 0 : $urandom_range(0, out_stall_max);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      check_result(out_data);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    sh_pat_lo     = '0;
    sh_pat_hi     = '0;
    sh_care       = '0;
    sh_len        = 5'd1;
    sh_report_all = 1'b1;
    clear_scan();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_zero_length();
    test_long_pattern();
    test_first_only();
    test_short_buffer();
    test_unknown_index();
    test_random_scan();
    drain();
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
